// File: hdl/uuid_v4_random_generator_unit_assert.svh
// assertion macros for the uuid generator checker
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef UUID_V4_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define UUID_V4_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UVG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uvg assertion failed");

// next-cycle implication, disabled during reset
`define UVG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uvg assertion failed");

`endif

// File: hdl/uvg_pkg.sv
// shared types and constants for the uuid v4 generator
// no dependencies
package uvg_pkg;

  // one finished uuid: 16 bytes, byte 0 in the low bits
  localparam int unsigned UuidBytes = 16;
  localparam int unsigned RecW      = 8 * UuidBytes;
  typedef logic [RecW-1:0] uvg_rec_t;

  // character output
  localparam int unsigned CharW     = 7;
  localparam int unsigned UuidChars = 36;
  localparam int unsigned PosW      = 6;

  localparam logic [CharW-1:0] CharDash  = 7'd45;
  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam logic [CharW-1:0] CharNine  = 7'd57;
  localparam logic [CharW-1:0] CharLowA  = 7'd97;
  localparam logic [CharW-1:0] CharLowF  = 7'd102;

endpackage

// File: hdl/uvg_front.sv
// request front end: runs the 12 lcg steps and builds one uuid record
// depends on uvg_pkg
module uvg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            seed_we_i,
  input  logic [31:0]     seed_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output uvg_pkg::uvg_rec_t q_data_o
);
  import uvg_pkg::*;

  localparam logic [31:0] LcgMul = 32'd1103515245;
  localparam logic [31:0] LcgAdd = 32'd12345;
  localparam logic [1:0]  LastSub  = 2'd2;
  localparam logic [1:0]  LastWord = 2'd3;

  logic        busy_q, busy_d;
  logic [31:0] lcg_q, lcg_d;
  logic [1:0]  sub_q, sub_d;
  logic [1:0]  word_q, word_d;
  logic [30:0] acc_q, acc_d;
  logic [30:0] words_q [3];

  logic [31:0] lcg_next;
  logic        last_step;
  logic        advance;
  logic [127:0] raw_rec;

  // one generator step per cycle while busy; the last step waits while the queue is full
  assign lcg_next  = lcg_q * LcgMul + LcgAdd;
  assign last_step = (sub_q == LastSub) && (word_q == LastWord);
  assign advance   = busy_q && !(last_step && q_full_i);

  // first step of a word takes 11 bits, the other two take 10
  always_comb begin
    if (sub_q == 2'd0) begin
      acc_d = {20'd0, lcg_next[26:16]};
    end else begin
      acc_d = {acc_q[20:0], lcg_next[25:16]};
    end
  end

  // record with version and variant bits
  always_comb begin
    raw_rec = {1'b0, acc_d, 1'b0, words_q[2], 1'b0, words_q[1], 1'b0, words_q[0]};
    q_data_o = raw_rec;
    q_data_o[55:48] = {4'h4, raw_rec[51:48]};
    q_data_o[71:64] = {2'b10, raw_rec[69:64]};
  end

  assign q_push_o = busy_q && last_step && !q_full_i;
  assign busy_o   = busy_q;

  // sequencing
  always_comb begin
    busy_d = busy_q;
    lcg_d  = lcg_q;
    sub_d  = sub_q;
    word_d = word_q;
    if (seed_we_i) begin
      lcg_d = seed_i;
    end
    if (!busy_q) begin
      if (req_valid_i && start_i) begin
        busy_d = 1'b1;
        sub_d  = 2'd0;
        word_d = 2'd0;
      end
    end else if (advance) begin
      lcg_d = lcg_next;
      if (sub_q == LastSub) begin
        sub_d  = 2'd0;
        word_d = word_q + 2'd1;
        if (word_q == LastWord) begin
          busy_d = 1'b0;
        end
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lcg_q  <= '0;
      sub_q  <= '0;
      word_q <= '0;
    end else begin
      busy_q <= busy_d;
      lcg_q  <= lcg_d;
      sub_q  <= sub_d;
      word_q <= word_d;
    end
  end

  // word accumulator and finished words
  always_ff @(posedge clk_i) begin
    if (advance) begin
      acc_q <= acc_d;
      if (sub_q == LastSub && word_q != LastWord) begin
        words_q[word_q] <= acc_d;
      end
    end
  end

endmodule

// File: hdl/uvg_queue.sv
// short record queue between generator and formatter
// depends on uvg_pkg; depth of 2 or more
module uvg_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uvg_pkg::uvg_rec_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output uvg_pkg::uvg_rec_t data_o,
  output logic              empty_o
);
  import uvg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  uvg_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/uvg_back.sv
// formatter: turns one record into 36 characters, hex digits with dashes
// depends on uvg_pkg
module uvg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  uvg_pkg::uvg_rec_t         q_data_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [uvg_pkg::CharW-1:0] char_code_o,
  output logic                      last_char_o
);
  import uvg_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;
  localparam logic [PosW-1:0] LastPos = PosW'(UuidChars - 1);

  typedef struct packed {
    logic       dash;
    logic [3:0] byte_idx;
    logic       high;
  } pos_map_t;

  // character position to byte and nibble
  function automatic pos_map_t map_pos(input logic [PosW-1:0] p);
    pos_map_t   m;
    logic [5:0] off;
    logic [3:0] base;
    m    = '0;
    off  = '0;
    base = '0;
    if (p < 6'd8) begin
      off = p;
      base = 4'd0;
    end else if (p == 6'd8 || p == 6'd13 || p == 6'd18 || p == 6'd23) begin
      m.dash = 1'b1;
    end else if (p < 6'd13) begin
      off = p - 6'd9;
      base = 4'd4;
    end else if (p < 6'd18) begin
      off = p - 6'd14;
      base = 4'd6;
    end else if (p < 6'd23) begin
      off = p - 6'd19;
      base = 4'd8;
    end else begin
      off = p - 6'd24;
      base = 4'd10;
    end
    m.byte_idx = base + off[4:1];
    m.high     = !off[0];
    return m;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CharZero + {3'd0, n};
    end
    return CharLowA + {3'd0, n} - 7'd10;
  endfunction

  logic             state_q, state_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  uvg_rec_t         rec_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  pos_map_t         pm;
  logic [7:0]       cur_byte;
  logic [3:0]       cur_nib;
  logic [CharW-1:0] cur_char;
  logic             out_free;
  logic             load_char;
  logic             load_rec;

  // current character
  assign pm       = map_pos(pos_q);
  assign cur_byte = rec_q[8*pm.byte_idx +: 8];
  assign cur_nib  = pm.high ? cur_byte[7:4] : cur_byte[3:0];
  assign cur_char = pm.dash ? CharDash : hex_char(cur_nib);
  assign out_free = !out_valid_q || pop_i;

  // emission sequencer
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    load_char = 1'b0;
    load_rec  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          load_rec = 1'b1;
          pos_d    = '0;
          state_d  = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          load_char = 1'b1;
          if (pos_q == LastPos) begin
            pos_d   = '0;
            state_d = StIdle;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    out_valid_d = load_char || (out_valid_q && !pop_i);
  end

  assign q_pop_o     = load_rec;
  assign empty_o     = !out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // record and output registers
  always_ff @(posedge clk_i) begin
    if (load_rec) begin
      rec_q <= q_data_i;
    end
    if (load_char) begin
      char_q <= cur_char;
      last_q <= (pos_q == LastPos);
    end
  end

endmodule

// File: hdl/uuid_v4_random_generator_unit.sv
// uuid v4 generator: one request yields 36 lower-case hex/dash characters
// throughput with pop held high is set by the formatter's
// 36 characters plus one record load; the 12 lcg steps overlap with emission
// reset: queue and output empty, generator state 0 until a seed is written
module uuid_v4_random_generator_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      start_request_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [uvg_pkg::CharW-1:0] char_code_o,
  output logic                      last_char_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [31:0]               seed_value_i
);
  import uvg_pkg::*;

  logic     front_busy;
  logic     q_push, q_full, q_pop, q_empty;
  uvg_rec_t q_wdata, q_rdata;

  assign full        = front_busy;
  assign cfg_ready_o = !front_busy;

  uvg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (push && !front_busy),
    .start_i     (start_request_i),
    .busy_o      (front_busy),
    .seed_we_i   (cfg_valid_i && cfg_ready_o),
    .seed_i      (seed_value_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  uvg_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  uvg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

// File: hdl/uvg_checker.sv
// port-level checks for the uuid generator, bound to the top level
// depends on uvg_pkg and uuid_v4_random_generator_unit_assert.svh
`include "uuid_v4_random_generator_unit_assert.svh"

module uvg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      push,
  input logic                      full,
  input logic                      start_request_i,
  input logic                      empty,
  input logic                      pop,
  input logic [uvg_pkg::CharW-1:0] char_code_o,
  input logic                      last_char_o
);
  import uvg_pkg::*;

  logic char_legal;
  logic req_taken;

  assign char_legal = (char_code_o == CharDash)
                   || (char_code_o >= CharZero && char_code_o <= CharNine)
                   || (char_code_o >= CharLowA && char_code_o <= CharLowF);
  assign req_taken  = push && !full && start_request_i;

  // only hex digits and dashes ever show
  `UVG_ASSERT_NOW(a_char_legal, !empty, char_legal)
  // the last character of a uuid is never a dash
  `UVG_ASSERT_NOW(a_last_not_dash, !empty && last_char_o, char_code_o != CharDash)
  // a real request keeps the generator busy in the next cycle
  `UVG_ASSERT_NEXT(a_busy_after_req, req_taken, full)
  // a waiting character holds until taken
  `UVG_ASSERT_NEXT(a_hold, !empty && !pop,
                   !empty && $stable(char_code_o) && $stable(last_char_o))

endmodule

bind uuid_v4_random_generator_unit uvg_checker u_uvg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .push            (push),
  .full            (full),
  .start_request_i (start_request_i),
  .empty           (empty),
  .pop             (pop),
  .char_code_o     (char_code_o),
  .last_char_o     (last_char_o)
);
